### rtl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// shared widths, character codes, action codes and the control bundles
// between the console controller and its datapath
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int POS_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int COLOUR_W  = 4;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef struct packed {
        logic load_item;
        logic exec_char;
        logic clear_cursor;
        logic div_start;
        logic div_step;
        logic mem_read;
        logic clr_step;
        logic load_out;
    } tcce_cmd_t;

    typedef struct packed {
        action_t action;
        logic    pos_ok;
        logic    clr_last;
    } tcce_status_t;

endpackage

### rtl/tcce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_datapath
// cursor, row and column registers, cell store, clear sweep, reciprocal
// row/column split, colour registers and the result register
// ----------------------------------------------------------------------------
module tcce_datapath #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcce_pkg::COLOUR_W-1:0]     cfg_data,
    input  logic [tcce_pkg::ACTION_W-1:0]     action,
    input  logic [tcce_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcce_pkg::POS_W-1:0]        position,
    input  logic                              write_last,
    input  tcce_pkg::tcce_cmd_t               cmd,
    output tcce_pkg::tcce_status_t            status,
    output logic                              byte_emitted,
    output logic [tcce_pkg::CHAR_W-1:0]       emitted_char,
    output logic                              scrolled,
    output logic [tcce_pkg::POS_W-1:0]        cursor_now,
    output logic [tcce_pkg::CHAR_W-1:0]       cell_value,
    output logic [tcce_pkg::COLOUR_W-1:0]     text_colour_out,
    output logic [tcce_pkg::COLOUR_W-1:0]     back_colour_out,
    output logic                              position_rejected,
    output logic                              write_done
);
    import tcce_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int EXT_W     = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;
    localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;
    localparam int DIV_SHIFT = EXT_W + COL_W;
    localparam int PROD_W    = 2 * EXT_W + 2;
    localparam int RECIP     = ((1 << DIV_SHIFT) + COLUMNS - 1) / COLUMNS;

    logic [CHAR_W-1:0] cell_mem [CELLS];
    logic [CHAR_W-1:0] rdata_reg;

    action_t           action_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;

    logic [ADDR_W-1:0] cursor_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [COLOUR_W-1:0] fg_reg;
    logic [COLOUR_W-1:0] bg_reg;

    logic [EXT_W-1:0]  pos_ext;
    logic [ADDR_W-1:0] pos_addr;
    logic              pos_ok;
    logic              is_nl;
    logic              is_cr;
    logic              at_last_col;
    logic              at_last_row;
    logic [ADDR_W-1:0] row_start;
    logic [ADDR_W-1:0] cursor_next;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic              scroll_next;
    logic [ADDR_W-1:0] cursor_after;
    logic [EXT_W-1:0]  cursor_ext;

    logic [PROD_W-1:0] pos_prod;
    logic [ROW_W-1:0]  pos_row;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] col_calc;
    logic              clr_last;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [CHAR_W-1:0] mem_wdata;

    // position check and address
    assign pos_ext  = EXT_W'(pos_reg);
    assign pos_ok   = pos_ext < EXT_W'(CELLS);
    assign pos_addr = pos_ext[ADDR_W-1:0];

    // character handling
    always_comb
    begin
        is_nl       = char_reg == CH_NEWLINE;
        is_cr       = char_reg == CH_RETURN;
        at_last_col = col_reg == COL_W'(COLUMNS - 1);
        at_last_row = row_reg == ROW_W'(ROWS - 1);
        row_start   = cursor_reg - ADDR_W'(col_reg);
        cursor_next = cursor_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        scroll_next = 1'b0;
        if (is_cr)
        begin
            cursor_next = row_start;
            col_next    = '0;
        end
        else if (is_nl || at_last_col)
        begin
            col_next = '0;
            if (at_last_row)
            begin
                scroll_next = 1'b1;
                cursor_next = ADDR_W'(LAST_ROW_START);
                row_next    = ROW_W'(ROWS - 1);
            end
            else
            begin
                cursor_next = is_nl ? row_start + ADDR_W'(COLUMNS) : cursor_reg + 1'b1;
                row_next    = row_reg + 1'b1;
            end
        end
        else
        begin
            cursor_next = cursor_reg + 1'b1;
            col_next    = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        unique case (action_reg)
            ACT_WRITE: cursor_after = cursor_next;
            ACT_SET:   cursor_after = pos_ok ? pos_addr : cursor_reg;
            default:   cursor_after = cursor_reg;
        endcase
    end

    assign cursor_ext = EXT_W'(cursor_after);

    // row of the new position by reciprocal multiply, column in the following cycle
    assign pos_prod = PROD_W'(pos_ext) * PROD_W'(RECIP);
    assign pos_row  = pos_prod[DIV_SHIFT +: ROW_W];
    assign row_base = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
    assign col_calc = cursor_reg - row_base;
    assign clr_last = clr_addr_reg == ADDR_W'(CELLS - 1);

    assign status.action   = action_reg;
    assign status.pos_ok   = pos_ok;
    assign status.clr_last = clr_last;

    // store port
    always_comb
    begin
        mem_we    = cmd.clr_step || (cmd.exec_char && !is_nl && !is_cr);
        mem_addr  = cmd.clr_step ? clr_addr_reg : cursor_reg;
        mem_wdata = cmd.clr_step ? CH_SPACE : char_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_read && pos_ok)
        begin
            rdata_reg <= cell_mem[pos_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            clr_addr_reg <= '0;
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_FOREGROUND)
                begin
                    fg_reg <= cfg_data;
                end
                else if (cfg_index == CFG_BACKGROUND)
                begin
                    bg_reg <= cfg_data;
                end
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.clear_cursor)
            begin
                cursor_reg <= '0;
                row_reg    <= '0;
                col_reg    <= '0;
            end
            else if (cmd.exec_char)
            begin
                cursor_reg <= cursor_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
            end
            else if (cmd.div_start)
            begin
                cursor_reg <= pos_addr;
                row_reg    <= pos_row;
            end
            else if (cmd.div_step)
            begin
                col_reg <= col_calc[COL_W-1:0];
            end
        end
    end

    // item and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action_t'(action);
            char_reg   <= char_code;
            pos_reg    <= position;
            last_reg   <= write_last;
        end
        if (cmd.load_out)
        begin
            byte_emitted      <= (action_reg == ACT_WRITE) && !is_cr;
            emitted_char      <= ((action_reg == ACT_WRITE) && !is_cr) ? char_reg : '0;
            scrolled          <= (action_reg == ACT_WRITE) && scroll_next;
            cursor_now        <= cursor_ext[POS_W-1:0];
            cell_value        <= ((action_reg == ACT_READ) && pos_ok) ? rdata_reg : '0;
            text_colour_out   <= fg_reg;
            back_colour_out   <= bg_reg;
            position_rejected <= ((action_reg == ACT_SET) || (action_reg == ACT_READ))
                                 && !pos_ok;
            write_done        <= (action_reg == ACT_WRITE) && last_reg;
        end
    end

endmodule

### rtl/tcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// sequencer for the console: reset sweep, item intake, action execution,
// row/column split and clear passes, result hand-off
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  tcce_pkg::tcce_status_t  status,
    output tcce_pkg::tcce_cmd_t     cmd
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.action)
                    ACT_WRITE:
                    begin
                        if (slot_free)
                        begin
                            cmd.exec_char = 1'b1;
                            cmd.load_out  = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    ACT_SET:
                    begin
                        if (slot_free)
                        begin
                            cmd.load_out = 1'b1;
                            if (status.pos_ok)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear_cursor = 1'b1;
                        state_next       = ST_CLEAR;
                    end
                    ACT_READ:
                    begin
                        cmd.mem_read = 1'b1;
                        state_next   = ST_DONE;
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// character-cell console: cursor tracking, cell store, scroll flagging
// ----------------------------------------------------------------------------
// After reset the block sweeps spaces through all COLUMNS*ROWS entries of
// the cell store before it takes its first beat; colour writes are taken
// at any time. One item is worked at a time on a single-port store. A
// character write, carriage return or newline is executed in one state after
// intake, waiting there while the output register is full; a read passes
// through an extra state because the store read is registered; a set cursor
// on screen finds the row by a reciprocal multiply and then the column in a
// further state, and a rejected one ends with no split; a clear writes one
// store entry per cycle. The input is taken while an earlier result still
// waits in the output register.
module text_console_cursor_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcce_pkg::COLOUR_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcce_pkg::ACTION_W-1:0]     action,
    input  logic [tcce_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcce_pkg::POS_W-1:0]        position,
    input  logic                              write_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              byte_emitted,
    output logic [tcce_pkg::CHAR_W-1:0]       emitted_char,
    output logic                              scrolled,
    output logic [tcce_pkg::POS_W-1:0]        cursor_now,
    output logic [tcce_pkg::CHAR_W-1:0]       cell_value,
    output logic [tcce_pkg::COLOUR_W-1:0]     text_colour_out,
    output logic [tcce_pkg::COLOUR_W-1:0]     back_colour_out,
    output logic                              position_rejected,
    output logic                              write_done
);
    import tcce_pkg::*;

    tcce_cmd_t    cmd;
    tcce_status_t status;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .action            (action),
        .char_code         (char_code),
        .position          (position),
        .write_last        (write_last),
        .cmd               (cmd),
        .status            (status),
        .byte_emitted      (byte_emitted),
        .emitted_char      (emitted_char),
        .scrolled          (scrolled),
        .cursor_now        (cursor_now),
        .cell_value        (cell_value),
        .text_colour_out   (text_colour_out),
        .back_colour_out   (back_colour_out),
        .position_rejected (position_rejected),
        .write_done        (write_done)
    );

    // one item in flight: intake closes right after a beat is taken
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input beat taken while an item is in flight");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result register loaded while occupied");

    // store port has a single writer per cycle
    a_port_owner: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec_char, cmd.clr_step, cmd.div_step, cmd.mem_read}))
        else $error("conflicting datapath commands");

    // a rejected position never comes with an emitted byte or a write done flag
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(position_rejected && (byte_emitted || write_done)))
        else $error("result mixes write and position fields");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the console cursor engine. A shadow copy of the
// cursor, the cell store and the colour registers predicts one result per
// accepted item, and each result is checked field by field in order. The
// stimulus is a directed part covering the screen edges, the newline, return
// and scroll cases and rejected positions, then random phases of write
// bursts, cursor moves, reads and a few clears under several colour settings.
// Each side idles at random in most phases, and neither does in a closing stretch.
// ----------------------------------------------------------------------------
module tb;

    import tcce_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic                byte_emitted;
        logic [CHAR_W-1:0]   emitted_char;
        logic                scrolled;
        logic [POS_W-1:0]    cursor_now;
        logic [CHAR_W-1:0]   cell_value;
        logic [COLOUR_W-1:0] text_colour;
        logic [COLOUR_W-1:0] back_colour;
        logic                position_rejected;
        logic                write_done;
    } console_out_t;

    function automatic string show(console_out_t r);
        return $sformatf("emit=%0d ch=%02h scr=%0d cur=%0d cell=%02h fg=%0d bg=%0d rej=%0d done=%0d",
                         r.byte_emitted, r.emitted_char, r.scrolled, r.cursor_now,
                         r.cell_value, r.text_colour, r.back_colour,
                         r.position_rejected, r.write_done);
    endfunction

    class console_shadow;
        int unsigned         cursor;
        logic [CHAR_W-1:0]   cells [CELLS];
        logic [COLOUR_W-1:0] fg;
        logic [COLOUR_W-1:0] bg;
        console_out_t        awaited[$];
        int                  failures;

        function new();
            cursor = 0;
            foreach (cells[i]) cells[i] = CH_SPACE;
            fg = FG_RESET;
            bg = BG_RESET;
            failures = 0;
        endfunction

        function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [COLOUR_W-1:0] val);
            if (idx == CFG_FOREGROUND)
                fg = val;
            else
                bg = val;
        endfunction

        function void take_item(action_t act, logic [CHAR_W-1:0] ch,
                                logic [POS_W-1:0] pos, logic last);
            console_out_t r;
            int unsigned  row;
            r = '0;
            r.text_colour = fg;
            r.back_colour = bg;
            if (cursor >= CELLS)
                cursor = CELLS - 1;
            case (act)
                ACT_WRITE:
                begin
                    r.write_done = last;
                    row = cursor / COLUMNS;
                    if (ch == CH_NEWLINE)
                    begin
                        r.byte_emitted = 1'b1;
                        r.emitted_char = ch;
                        if (row + 1 >= ROWS)
                        begin
                            r.scrolled = 1'b1;
                            cursor = (ROWS - 1) * COLUMNS;
                        end
                        else
                        begin
                            cursor = (row + 1) * COLUMNS;
                        end
                    end
                    else if (ch == CH_RETURN)
                    begin
                        cursor = row * COLUMNS;
                    end
                    else
                    begin
                        r.byte_emitted = 1'b1;
                        r.emitted_char = ch;
                        cells[cursor] = ch;
                        cursor++;
                        if (cursor >= CELLS)
                        begin
                            r.scrolled = 1'b1;
                            cursor = (ROWS - 1) * COLUMNS;
                        end
                    end
                end
                ACT_SET:
                begin
                    if (pos < CELLS)
                        cursor = pos;
                    else
                        r.position_rejected = 1'b1;
                end
                ACT_CLEAR:
                begin
                    foreach (cells[i]) cells[i] = CH_SPACE;
                    cursor = 0;
                end
                default:
                begin
                    if (pos < CELLS)
                        r.cell_value = cells[pos];
                    else
                        r.position_rejected = 1'b1;
                end
            endcase
            r.cursor_now = cursor[POS_W-1:0];
            awaited.push_back(r);
        endfunction

        function void check_result(console_out_t got);
            console_out_t exp;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t unexpected result: %s", $realtime, show(got));
                return;
            end
            exp = awaited.pop_front();
            if (got.byte_emitted !== exp.byte_emitted
                || got.emitted_char !== exp.emitted_char
                || got.scrolled !== exp.scrolled
                || got.cursor_now !== exp.cursor_now
                || got.cell_value !== exp.cell_value
                || got.text_colour !== exp.text_colour
                || got.back_colour !== exp.back_colour
                || got.position_rejected !== exp.position_rejected
                || got.write_done !== exp.write_done)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("%0t mismatch", $realtime);
                    $display("    expected %s", show(exp));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOUR_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action;
    logic [CHAR_W-1:0]    char_code;
    logic [POS_W-1:0]     position;
    logic                 write_last;
    logic                 out_valid;
    logic                 out_stall;
    logic                 byte_emitted;
    logic [CHAR_W-1:0]    emitted_char;
    logic                 scrolled;
    logic [POS_W-1:0]     cursor_now;
    logic [CHAR_W-1:0]    cell_value;
    logic [COLOUR_W-1:0]  text_colour_out;
    logic [COLOUR_W-1:0]  back_colour_out;
    logic                 position_rejected;
    logic                 write_done;

    console_shadow shadow = new();
    int            tx_odds = 4;
    int            rx_odds = 4;
    int unsigned   cycle_count = 0;

    text_console_cursor_engine u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .char_code         (char_code),
        .position          (position),
        .write_last        (write_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .byte_emitted      (byte_emitted),
        .emitted_char      (emitted_char),
        .scrolled          (scrolled),
        .cursor_now        (cursor_now),
        .cell_value        (cell_value),
        .text_colour_out   (text_colour_out),
        .back_colour_out   (back_colour_out),
        .position_rejected (position_rejected),
        .write_done        (write_done)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin : beat_monitor
        console_out_t seen;
        if (rst_n && in_valid && !in_stall)
            shadow.take_item(action_t'(action), char_code, position, write_last);
        if (rst_n && out_valid && !out_stall)
        begin
            seen.byte_emitted      = byte_emitted;
            seen.emitted_char      = emitted_char;
            seen.scrolled          = scrolled;
            seen.cursor_now        = cursor_now;
            seen.cell_value        = cell_value;
            seen.text_colour       = text_colour_out;
            seen.back_colour       = back_colour_out;
            seen.position_rejected = position_rejected;
            seen.write_done        = write_done;
            shadow.check_result(seen);
        end
    end

    initial
    begin : rx_stall
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
            begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[text_console_cursor_engine] ERROR");
        $finish;
    end

    task automatic send_beat(action_t act, logic [CHAR_W-1:0] ch,
                             logic [POS_W-1:0] pos, logic last);
        int gap;
        if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        char_code  <= ch;
        position   <= pos;
        write_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FOREGROUND;
        cfg_data  <= fg;
        shadow.set_colour(CFG_FOREGROUND, fg);
        @(posedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        shadow.set_colour(CFG_BACKGROUND, bg);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return CH_NEWLINE;
        if (p < 15)
            return CH_RETURN;
        if (p < 75)
            return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int p;
        p = $urandom_range(0, 99);
        if (p < 12)
            return POS_W'($urandom_range(CELLS, 2047));
        if (p < 40)
            return POS_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
        if (p < 65)
            return POS_W'((shadow.cursor + CELLS - $urandom_range(0, 40)) % CELLS);
        return POS_W'($urandom_range(0, CELLS - 1));
    endfunction

    task automatic run_random(int count);
        int   sent;
        int   len;
        int   pick;
        logic last;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        last = 1'($urandom);
                    else
                        last = (k == len - 1);
                    send_beat(ACT_WRITE, pick_char(), POS_W'($urandom), last);
                end
                sent += len;
            end
            else
            begin
                if (pick < 72)
                    send_beat(ACT_SET, CHAR_W'($urandom), pick_position(), 1'($urandom));
                else if (pick < 99)
                    send_beat(ACT_READ, CHAR_W'($urandom), pick_position(), 1'($urandom));
                else
                    send_beat(ACT_CLEAR, CHAR_W'($urandom), POS_W'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin : main
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_FOREGROUND;
        cfg_data   = '0;
        in_valid   = 1'b0;
        action     = ACT_WRITE;
        char_code  = '0;
        position   = '0;
        write_last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset colours, screen edges, newline, return, scroll, rejected positions and a clear
        send_beat(ACT_READ,  8'h00, 11'd0,    1'b0);
        send_beat(ACT_READ,  8'h00, 11'd1999, 1'b1);
        send_beat(ACT_READ,  8'hFF, 11'd2000, 1'b0);
        send_beat(ACT_READ,  8'h00, 11'd2047, 1'b0);
        send_beat(ACT_WRITE, 8'h41, 11'd0,    1'b0);
        send_beat(ACT_WRITE, 8'h00, 11'd0,    1'b0);
        send_beat(ACT_WRITE, 8'hFF, 11'd2047, 1'b1);
        send_beat(ACT_WRITE, CH_RETURN,  11'd0, 1'b0);
        send_beat(ACT_WRITE, CH_RETURN,  11'd0, 1'b0);
        send_beat(ACT_WRITE, CH_NEWLINE, 11'd0, 1'b1);
        send_beat(ACT_SET,   8'h00, 11'd2047, 1'b0);
        send_beat(ACT_SET,   8'h00, 11'd2000, 1'b0);
        send_beat(ACT_SET,   8'h00, 11'd1999, 1'b0);
        send_beat(ACT_WRITE, 8'h5A, 11'd0,    1'b1);
        send_beat(ACT_WRITE, CH_NEWLINE, 11'd0, 1'b1);
        send_beat(ACT_SET,   8'h00, 11'd1919, 1'b0);
        send_beat(ACT_WRITE, 8'h71, 11'd0,    1'b1);
        send_beat(ACT_READ,  8'h00, 11'd1999, 1'b0);
        send_beat(ACT_READ,  8'h00, 11'd0,    1'b0);
        send_beat(ACT_READ,  8'h00, 11'd2,    1'b0);
        send_beat(ACT_CLEAR, 8'h00, 11'd0,    1'b0);
        send_beat(ACT_READ,  8'h00, 11'd1999, 1'b0);
        send_beat(ACT_SET,   8'h00, 11'd0,    1'b0);
        send_beat(ACT_WRITE, CH_NEWLINE, 11'd0, 1'b0);
        drain();

        set_colours(4'd15, 4'd15);
        tx_odds = 3;
        rx_odds = 3;
        run_random(300);
        drain();

        set_colours(4'd0, 4'd0);
        tx_odds = 0;
        rx_odds = 5;
        run_random(300);
        drain();

        set_colours(4'd0, 4'd15);
        tx_odds = 6;
        rx_odds = 0;
        run_random(300);
        drain();

        set_colours(4'd15, 4'd0);
        tx_odds = 2;
        rx_odds = 2;
        run_random(300);
        drain();

        set_colours(COLOUR_W'($urandom), COLOUR_W'($urandom));
        tx_odds = 4;
        rx_odds = 4;
        run_random(300);
        drain();

        // closing stretch with no idling on either side
        set_colours(COLOUR_W'($urandom), COLOUR_W'($urandom));
        tx_odds = 0;
        rx_odds = 0;
        run_random(300);
        drain();

        repeat (40) @(posedge clk);
        if (shadow.failures == 0 && shadow.awaited.size() == 0)
            $display("[text_console_cursor_engine] OK");
        else
            $display("[text_console_cursor_engine] ERROR");
        $finish;
    end

endmodule

### text_console_cursor_engine.f
rtl/tcce_pkg.sv
rtl/tcce_datapath.sv
rtl/tcce_ctrl.sv
rtl/text_console_cursor_engine.sv
verif/tb.sv
